// ----- design/tce_pkg.sv -----
package tce_pkg;

  // default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // request and result field widths
  localparam int CHAR_W       = 8;
  localparam int COLOR_W      = 8;
  localparam int READ_ROW_W   = 5;
  localparam int READ_COL_W   = 7;
  localparam int CURSOR_ROW_W = 5;
  localparam int CURSOR_COL_W = 7;
  localparam int CELL_W       = CHAR_W + COLOR_W;

  // register port
  localparam int APB_AW = 2;
  localparam int APB_DW = 32;
  localparam int REG_TEXT_COLOR = 0;
  localparam logic [APB_AW-1:0] TEXT_COLOR_ADDR = APB_AW'(4 * REG_TEXT_COLOR);

  // request kinds
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // control characters
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // attribute and cell after reset
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
  localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_SPACE};

endpackage

// ----- design/text_console_cursor_engine.sv -----
// Text console with a ROWS x COLUMNS screen memory (one write port, one
// registered read port) and a cursor. After reset a clearing pass fills the
// memory with light-grey spaces, one cell a cycle, during which cmd_stall
// stays high; register writes are taken as ever. Scrolling moves no data:
// the top row is a rotating pointer, so a scroll only rewrites the new
// bottom line. A request passes through the states it needs: a read goes
// through S_READ to pick up the memory data, a tab through S_TAB, which
// writes one space per cell up to the next tab stop, and a new line from
// the last row through S_SCROLL; each ends in S_FIN, which hands the result
// over. A finished result waits in the output register while the next
// request is taken.
module text_console_cursor_engine
  import tce_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                    clk,
  input  logic                    rst,
  // register port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  // request channel
  input  logic                    cmd_valid,
  output logic                    cmd_stall,
  input  logic                    command,
  input  logic [CHAR_W-1:0]       char_code,
  input  logic [READ_ROW_W-1:0]   read_row,
  input  logic [READ_COL_W-1:0]   read_col,
  // result channel
  output logic                    res_valid,
  input  logic                    res_stall,
  output logic [CURSOR_ROW_W-1:0] cursor_row,
  output logic [CURSOR_COL_W-1:0] cursor_col,
  output logic [CHAR_W-1:0]       cell_char,
  output logic [COLOR_W-1:0]      cell_color,
  output logic                    scrolled
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_TAB    = 6'b001000,
    S_SCROLL = 6'b010000,
    S_FIN    = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [RW-1:0]     cur_row, cur_row_next;
  logic [CW-1:0]     cur_col, cur_col_next;
  logic [AW-1:0]     cur_base, cur_base_next;
  logic [RW-1:0]     top_row, top_row_next;
  logic [AW-1:0]     top_base, top_base_next;
  logic [AW-1:0]     sweep, sweep_next;
  logic              scr, scr_next;
  logic              rd_ok, rd_ok_next;
  logic [CELL_W-1:0] res_cell, res_cell_next;
  logic [COLOR_W-1:0] text_color;

  // screen memory
  logic [CELL_W-1:0] screen [DEPTH];
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  // address helpers
  logic [CW:0]   col_inc;
  logic          col_end;
  logic [AW:0]   base_sum, top_sum;
  logic [AW-1:0] base_adv, top_adv, cell_addr;
  logic [RW-1:0] top_row_inc, rr, prow;
  logic [RW:0]   prow_sum;
  logic          last_row, rd_in, do_newline, slot_free;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr == TEXT_COLOR_ADDR) ? APB_DW'(text_color) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= RESET_COLOR;
    end else if (psel && penable && pwrite && pready && paddr == TEXT_COLOR_ADDR) begin
      text_color <= pwdata[COLOR_W-1:0];
    end
  end

  assign cmd_stall = (state != S_IDLE);
  assign slot_free = !res_valid || !res_stall;

  // cursor and row pointer arithmetic
  assign col_inc     = {1'b0, cur_col} + (CW + 1)'(1);
  assign col_end     = (col_inc == (CW + 1)'(COLUMNS));
  assign base_sum    = {1'b0, cur_base} + (AW + 1)'(COLUMNS);
  assign base_adv    = (base_sum == (AW + 1)'(DEPTH)) ? '0 : base_sum[AW-1:0];
  assign top_sum     = {1'b0, top_base} + (AW + 1)'(COLUMNS);
  assign top_adv     = (top_sum == (AW + 1)'(DEPTH)) ? '0 : top_sum[AW-1:0];
  assign top_row_inc = (top_row == RW'(ROWS - 1)) ? '0 : top_row + RW'(1);
  assign last_row    = (cur_row == RW'(ROWS - 1));
  assign cell_addr   = cur_base + AW'(cur_col);

  // read address: screen row rotated by the top row pointer
  assign rd_in    = (int'(read_row) < ROWS) && (int'(read_col) < COLUMNS);
  assign rr       = RW'(read_row);
  assign prow_sum = {1'b0, rr} + {1'b0, top_row};
  assign prow     = (prow_sum >= (RW + 1)'(ROWS)) ? RW'(prow_sum - (RW + 1)'(ROWS))
                                                  : prow_sum[RW-1:0];
  assign raddr    = AW'(AW'(prow) * AW'(COLUMNS) + AW'(read_col));

  // sequencer
  always_comb begin
    state_next    = state;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    cur_base_next = cur_base;
    top_row_next  = top_row;
    top_base_next = top_base;
    sweep_next    = sweep;
    scr_next      = scr;
    rd_ok_next    = rd_ok;
    res_cell_next = res_cell;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = cell_addr;
    wdata         = {text_color, CH_SPACE};
    do_newline    = 1'b0;
    case (state)
      S_CLEAR: begin
        we         = 1'b1;
        waddr      = sweep;
        wdata      = RESET_CELL;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          scr_next      = 1'b0;
          res_cell_next = '0;
          case (command)
            CMD_READ: begin
              re         = rd_in;
              rd_ok_next = rd_in;
              state_next = S_READ;
            end
            CMD_PUT: begin
              state_next = S_FIN;
              case (char_code)
                CH_NEWLINE: begin
                  do_newline = 1'b1;
                end
                CH_RETURN: begin
                  cur_col_next = '0;
                end
                CH_BACKSPACE: begin
                  if (cur_col != '0) begin
                    we           = 1'b1;
                    waddr        = cell_addr - AW'(1);
                    cur_col_next = cur_col - CW'(1);
                  end
                end
                CH_TAB: begin
                  state_next = S_TAB;
                end
                default: begin
                  we    = 1'b1;
                  wdata = {text_color, char_code};
                  if (col_end) begin
                    do_newline = 1'b1;
                  end else begin
                    cur_col_next = col_inc[CW-1:0];
                  end
                end
              endcase
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_READ: begin
        if (rd_ok) begin
          res_cell_next = rdata;
        end
        state_next = S_FIN;
      end
      S_TAB: begin
        // one space per cycle up to the next tab stop or the row end
        we = 1'b1;
        if (col_end) begin
          do_newline = 1'b1;
        end else begin
          cur_col_next = col_inc[CW-1:0];
          if (col_inc[1:0] == 2'b00) begin
            state_next = S_FIN;
          end
        end
      end
      S_SCROLL: begin
        // blank the new bottom line in the current color
        we         = 1'b1;
        waddr      = cur_base + sweep;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(COLUMNS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // move to the next line, scrolling from the last row
    if (do_newline) begin
      cur_col_next = '0;
      if (last_row) begin
        scr_next      = 1'b1;
        cur_base_next = top_base;
        top_base_next = top_adv;
        top_row_next  = top_row_inc;
        sweep_next    = '0;
        state_next    = S_SCROLL;
      end else begin
        cur_row_next  = cur_row + RW'(1);
        cur_base_next = base_adv;
        state_next    = S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cur_row  <= '0;
      cur_col  <= '0;
      cur_base <= '0;
      top_row  <= '0;
      top_base <= '0;
      sweep    <= '0;
    end else begin
      state    <= state_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      cur_base <= cur_base_next;
      top_row  <= top_row_next;
      top_base <= top_base_next;
      sweep    <= sweep_next;
    end
  end

  always_ff @(posedge clk) begin
    scr      <= scr_next;
    rd_ok    <= rd_ok_next;
    res_cell <= res_cell_next;
  end

  // screen memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      screen[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= screen[raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && slot_free) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && slot_free) begin
      cursor_row <= CURSOR_ROW_W'(cur_row);
      cursor_col <= CURSOR_COL_W'(cur_col);
      cell_char  <= res_cell[CHAR_W-1:0];
      cell_color <= res_cell[CELL_W-1:CHAR_W];
      scrolled   <= scr;
    end
  end

endmodule

// ----- design/tce_checker.sv -----
module tce_checker
  import tce_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    cmd_valid,
  input logic                    cmd_stall,
  input logic                    res_valid,
  input logic                    res_stall,
  input logic [CURSOR_ROW_W-1:0] cursor_row,
  input logic [CURSOR_COL_W-1:0] cursor_col,
  input logic [CHAR_W-1:0]       cell_char,
  input logic [COLOR_W-1:0]      cell_color,
  input logic                    scrolled
);

  // reset starts the clearing pass, so no request is taken right after it
  a_reset_busy: assert property (@(posedge clk) rst |=> cmd_stall)
    else $error("request taken right after reset");

  // one request at a time: busy in the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("request taken while the previous one is still in work");

  // a scroll parks the cursor at the bottom left
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (res_valid && scrolled) |->
      (cursor_col == '0 && cursor_row == CURSOR_ROW_W'(ROWS - 1)))
    else $error("scroll left the cursor off the bottom left");

  // a result held back keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=>
      (res_valid && $stable(cursor_row) && $stable(cursor_col) &&
       $stable(cell_char) && $stable(cell_color) && $stable(scrolled)))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_engine tce_checker #(
  .COLUMNS(COLUMNS),
  .ROWS   (ROWS)
) u_tce_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .cursor_row(cursor_row),
  .cursor_col(cursor_col),
  .cell_char (cell_char),
  .cell_color(cell_color),
  .scrolled  (scrolled)
);
